@@ hw/rtl/refcounted_page_allocator_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Refcounted page allocator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RPA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpa assertion failed");

// next-cycle implication
`define RPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpa assertion failed");

`endif

@@ hw/rtl/rpa_pkg.sv @@
// ---------------------------------------------------------------------------
// Refcounted page allocator package
// Widths, request/response types, codes and state encodings.
// ---------------------------------------------------------------------------
package rpa_pkg;

  localparam int PAGE_BITS  = 14;
  localparam int COUNT_BITS = 16;
  localparam int REG_BITS   = PAGE_BITS + 1;
  localparam int PAGE_DEPTH = 1 << PAGE_BITS;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [REG_BITS-1:0] STACK_DEPTH = REG_BITS'(PAGE_DEPTH);

  typedef enum logic [1:0] {
    FUNC_ALLOC    = 2'd0,
    FUNC_FREE     = 2'd1,
    FUNC_ADD_REF  = 2'd2,
    FUNC_READ_REF = 2'd3
  } rpa_func_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_FREE     = 2'd1,
    STAT_NOT_MANAGED = 2'd2,
    STAT_STACK_FULL  = 2'd3
  } rpa_status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POOL_START  = 2'd0,
    CFG_POOL_END    = 2'd1,
    CFG_EXTRA_LIMIT = 2'd2
  } rpa_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } rpa_state_t;

  typedef struct packed {
    rpa_func_t              func;
    logic [PAGE_BITS-1:0]   page;
  } rpa_in_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0]   result_page;
    logic [COUNT_BITS-1:0]  ref_count;
    rpa_status_t            status;
    logic                   managed;
    logic                   released;
  } rpa_out_t;

  typedef struct packed {
    logic                   rd_en;
    logic [PAGE_BITS-1:0]   rd_addr;
    logic                   wr_en;
    logic [PAGE_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0]  wr_data;
  } rpa_cnt_req_t;

endpackage

@@ hw/rtl/rpa_refcnt.sv @@
// ---------------------------------------------------------------------------
// Reference count store
// One-port-read, one-port-write count memory with a zeroing sweep after reset.
// ---------------------------------------------------------------------------
module rpa_refcnt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rpa_pkg::rpa_cnt_req_t          req,
  output logic [rpa_pkg::COUNT_BITS-1:0] rd_data,
  output logic                           clr_busy
);

  logic [rpa_pkg::COUNT_BITS-1:0] mem [rpa_pkg::PAGE_DEPTH];
  logic [rpa_pkg::COUNT_BITS-1:0] rd_data_r;
  logic [rpa_pkg::REG_BITS-1:0]   clr_idx_r;
  logic [rpa_pkg::REG_BITS-1:0]   clr_idx_nxt;

  assign clr_busy    = !clr_idx_r[rpa_pkg::PAGE_BITS];
  assign clr_idx_nxt = clr_busy ? clr_idx_r + rpa_pkg::REG_BITS'(1) : clr_idx_r;
  assign rd_data     = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else begin
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_idx_r[rpa_pkg::PAGE_BITS-1:0]] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

@@ hw/rtl/refcounted_page_allocator_unit.sv @@
// ---------------------------------------------------------------------------
// Refcounted page allocator
// LIFO free-page stack with per-page reference counts.
// ---------------------------------------------------------------------------
// A request is accepted in ST_IDLE and completed in ST_EXEC: the accept cycle
// reads the count memory at the request page and the stack memory at its top;
// ST_EXEC runs one shared +1/-1 count adder and writes the count memory and, on
// a release, the stack memory, as the function requires. The response sits in
// an output register, so a new request is accepted while the last response
// waits; ST_EXEC stretches only if that register is still full. After reset the
// count memory is zeroed one entry per cycle; in_ready stays low for that time
// and until the state leaves ST_CLEAR, configuration writes are taken throughout.
`include "refcounted_page_allocator_unit_defines.svh"

module refcounted_page_allocator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rpa_pkg::rpa_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rpa_pkg::rpa_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rpa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rpa_pkg::REG_BITS-1:0]        cfg_data
);

  localparam int PB = rpa_pkg::PAGE_BITS;
  localparam int CB = rpa_pkg::COUNT_BITS;
  localparam int RB = rpa_pkg::REG_BITS;

  rpa_pkg::rpa_state_t   state_r, state_nxt;
  rpa_pkg::rpa_in_t      req_r;
  logic                  managed_r;
  logic                  managed_nxt;
  logic [RB-1:0]         pool_start_r, pool_end_r, extra_limit_r;
  logic [RB-1:0]         stack_count_r, stack_count_nxt;
  logic [RB-1:0]         stack_count_dec;
  logic                  out_valid_r;
  rpa_pkg::rpa_out_t     out_r, out_nxt;

  logic [PB-1:0]         stack_mem [rpa_pkg::PAGE_DEPTH];
  logic [PB-1:0]         stk_rdata_r;
  logic                  stk_re, stk_we;
  logic [PB-1:0]         stk_raddr, stk_waddr;

  rpa_pkg::rpa_cnt_req_t cnt_req;
  logic [CB-1:0]         cnt_rdata;
  logic                  clr_busy;

  logic                  accept;
  logic                  out_free;
  logic                  exec;
  logic                  cnt_dec;
  logic [CB-1:0]         cnt_sum;
  logic [RB-1:0]         pg_ext;

  rpa_refcnt u_refcnt (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (cnt_req),
    .rd_data  (cnt_rdata),
    .clr_busy (clr_busy)
  );

  assign out_free        = !out_valid_r || out_ready;
  assign accept          = in_valid && in_ready;
  assign exec            = (state_r == rpa_pkg::ST_EXEC) && out_free;
  assign stack_count_dec = stack_count_r - RB'(1);
  assign pg_ext          = {1'b0, in_data.page};
  assign managed_nxt     = ((pg_ext >= pool_start_r) && (pg_ext < pool_end_r)) ||
                           (pg_ext < extra_limit_r);

  // shared count unit: +1 or -1
  assign cnt_dec = (req_r.func == rpa_pkg::FUNC_FREE);
  assign cnt_sum = cnt_rdata + (cnt_dec ? {CB{1'b1}} : CB'(1));

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpa_pkg::ST_CLEAR: begin
        if (!clr_busy) state_nxt = rpa_pkg::ST_IDLE;
      end
      rpa_pkg::ST_IDLE: begin
        if (accept) state_nxt = rpa_pkg::ST_EXEC;
      end
      rpa_pkg::ST_EXEC: begin
        if (out_free) state_nxt = rpa_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready        = (state_r == rpa_pkg::ST_IDLE);
    stk_re          = accept;
    stk_raddr       = stack_count_dec[PB-1:0];
    stk_we          = 1'b0;
    stk_waddr       = stack_count_r[PB-1:0];
    cnt_req.rd_en   = accept;
    cnt_req.rd_addr = in_data.page;
    cnt_req.wr_en   = 1'b0;
    cnt_req.wr_addr = req_r.page;
    cnt_req.wr_data = cnt_sum;
    stack_count_nxt = stack_count_r;
    out_nxt.result_page = '0;
    out_nxt.ref_count   = '0;
    out_nxt.status      = rpa_pkg::STAT_OK;
    out_nxt.managed     = managed_r;
    out_nxt.released    = 1'b0;
    unique case (req_r.func)
      rpa_pkg::FUNC_ALLOC: begin
        if (stack_count_r == '0) begin
          out_nxt.status = rpa_pkg::STAT_NO_FREE;
        end else begin
          stack_count_nxt     = stack_count_dec;
          cnt_req.wr_en       = exec;
          cnt_req.wr_addr     = stk_rdata_r;
          cnt_req.wr_data     = CB'(1);
          out_nxt.result_page = stk_rdata_r;
          out_nxt.ref_count   = CB'(1);
        end
      end
      rpa_pkg::FUNC_FREE: begin
        if (!managed_r) begin
          out_nxt.status = rpa_pkg::STAT_NOT_MANAGED;
        end else begin
          if (cnt_rdata != '0) begin
            cnt_req.wr_en     = exec;
            out_nxt.ref_count = cnt_sum;
          end
          if ((cnt_rdata == '0) || (cnt_sum == '0)) begin
            if (stack_count_r == rpa_pkg::STACK_DEPTH) begin
              out_nxt.status = rpa_pkg::STAT_STACK_FULL;
            end else begin
              stk_we           = exec;
              stack_count_nxt  = stack_count_r + RB'(1);
              out_nxt.released = 1'b1;
            end
          end
        end
      end
      rpa_pkg::FUNC_ADD_REF: begin
        if (!managed_r) begin
          out_nxt.status = rpa_pkg::STAT_NOT_MANAGED;
        end else begin
          cnt_req.wr_en     = exec;
          out_nxt.ref_count = cnt_sum;
        end
      end
      rpa_pkg::FUNC_READ_REF: begin
        if (!managed_r) begin
          out_nxt.status = rpa_pkg::STAT_NOT_MANAGED;
        end else begin
          out_nxt.ref_count = cnt_rdata;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rpa_pkg::ST_CLEAR;
      stack_count_r <= '0;
      out_valid_r   <= 1'b0;
      pool_start_r  <= '0;
      pool_end_r    <= '0;
      extra_limit_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        stack_count_r <= stack_count_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rpa_pkg::CFG_POOL_START:  pool_start_r  <= cfg_data;
          rpa_pkg::CFG_POOL_END:    pool_end_r    <= cfg_data;
          rpa_pkg::CFG_EXTRA_LIMIT: extra_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_data;
      managed_r <= managed_nxt;
    end
    if (exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= req_r.page;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_re) begin
      stk_rdata_r <= stack_mem[stk_raddr];
    end
  end

  `RPA_ASSERT_SAME(a_no_accept_in_clear, state_r == rpa_pkg::ST_CLEAR, !in_ready)
  `RPA_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_r == rpa_pkg::ST_EXEC)
  `RPA_ASSERT_SAME(a_stack_bound, 1'b1, stack_count_r <= rpa_pkg::STACK_DEPTH)
  `RPA_ASSERT_SAME(a_release_ok, out_valid && out_data.released, out_data.status == rpa_pkg::STAT_OK)
  `RPA_ASSERT_NEXT(a_count_in_exec, state_r != rpa_pkg::ST_EXEC, $stable(stack_count_r))

endmodule
